[hdl/ntsm_pkg.sv]
// Shared types and constants of the noise and tone sound mixer.
// Used by every module of the block; depends on nothing.
package ntsm_pkg;

    localparam int SAMPLE_RATE_DEF = 44100;
    localparam int CPU_CLOCK_DEF   = 1512000;

    localparam int MAX_SAMPLES = 15;
    localparam int MAX_CYCLES  = 15;
    localparam int CNT_W       = $clog2(MAX_SAMPLES);

    localparam logic [14:0] ADDR_EXPLODE    = 15'h3600;
    localparam logic [14:0] ADDR_THUMP      = 15'h3a00;
    localparam logic [14:0] ADDR_ENABLE     = 15'h3c00;
    localparam logic [14:0] ADDR_ENABLE_END = 15'h3c05;

    localparam int NUM_ENABLE = 6;
    localparam int EN_TONE_A  = 0;
    localparam int EN_TONE_B  = 1;
    localparam int EN_A_HIGH  = 2;
    localparam int EN_NOISE   = 3;
    localparam int EN_SHOT    = 4;
    localparam int EN_THRUST  = 5;

    localparam int PH_A      = 0;
    localparam int PH_B      = 1;
    localparam int PH_THRUST = 2;
    localparam int PH_THUMP  = 3;
    localparam int NUM_PH    = 4;

    localparam int FREQ_LOW    = 441;
    localparam int FREQ_HIGH   = 737;
    localparam int FREQ_B      = 2800;
    localparam int FREQ_THRUST = 1500;

    localparam int AMP_NOISE  = 2500;
    localparam int AMP_THUMP  = 4500;
    localparam int AMP_A      = 2800;
    localparam int AMP_B      = 2200;
    localparam int AMP_SHOT   = 5500;
    localparam int AMP_THRUST = 3500;

    localparam int CMDQ_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_EXPLODE,
        CMD_THUMP,
        CMD_ENABLE,
        CMD_CYCLES
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  data;
        logic [2:0]  idx;
    } t_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_back_state;

endpackage

[hdl/ntsm_front.sv]
// Front end: accepts input items and classifies them into commands.
// Depends on ntsm_pkg; feeds ntsm_cmdq.
module ntsm_front (
    input  logic              i_push,
    output logic              o_full,
    input  logic              i_req_type,
    input  logic [15:0]       i_address,
    input  logic [7:0]        i_write_value,
    input  logic [3:0]        i_cycles,
    input  logic              i_q_full,
    output logic              o_q_wr,
    output ntsm_pkg::t_cmd    o_q_cmd
);
    import ntsm_pkg::*;

    logic [14:0] a15;
    logic        keep;

    assign a15    = i_address[14:0];
    assign o_full = i_q_full;

    always_comb begin
        keep          = 1'b0;
        o_q_cmd.kind  = CMD_CYCLES;
        o_q_cmd.data  = i_write_value;
        o_q_cmd.idx   = a15[2:0];
        if (i_req_type) begin
            o_q_cmd.data = {4'b0000, i_cycles};
            keep         = (i_cycles != 4'd0);
        end else if (a15 == ADDR_EXPLODE) begin
            o_q_cmd.kind = CMD_EXPLODE;
            keep         = 1'b1;
        end else if (a15 == ADDR_THUMP) begin
            o_q_cmd.kind = CMD_THUMP;
            keep         = 1'b1;
        end else if (a15 inside {[ADDR_ENABLE:ADDR_ENABLE_END]}) begin
            o_q_cmd.kind = CMD_ENABLE;
            keep         = 1'b1;
        end
    end

    // drop ignored writes and empty cycle reports
    assign o_q_wr = i_push && !i_q_full && keep;

endmodule

[hdl/ntsm_cmdq.sv]
// Short command queue between front and back end.
// Depends on ntsm_pkg for the command type and depth.
module ntsm_cmdq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  ntsm_pkg::t_cmd    i_cmd,
    output logic              o_full,
    input  logic              i_rd,
    output logic              o_valid,
    output ntsm_pkg::t_cmd    o_cmd
);
    import ntsm_pkg::*;

    localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CNT_QW = $clog2(CMDQ_DEPTH + 1);

    t_cmd              r_mem [CMDQ_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_QW-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_QW'(CMDQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr && i_rd) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[hdl/ntsm_back.sv]
// Back end: sound state, rate accumulator, sample mixer and result register.
// Depends on ntsm_pkg; takes commands from ntsm_cmdq.
module ntsm_back #(
    parameter int SAMPLE_RATE = ntsm_pkg::SAMPLE_RATE_DEF,
    parameter int CPU_CLOCK   = ntsm_pkg::CPU_CLOCK_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  ntsm_pkg::t_cmd    i_cmd,
    output logic              o_cmd_pop,
    input  logic              i_out_pop,
    output logic              o_out_valid,
    output logic [15:0]       o_sample,
    output logic              o_last_sample
);
    import ntsm_pkg::*;

    localparam int ACC_W       = $clog2(CPU_CLOCK + MAX_CYCLES * SAMPLE_RATE + 1);
    localparam int EXPLODE_LEN = SAMPLE_RATE / 3;
    localparam int SHOT_LEN    = SAMPLE_RATE / 18;
    localparam int EXP_W       = $clog2(EXPLODE_LEN + 1);
    localparam int SHOT_W      = $clog2(SHOT_LEN + 1);
    localparam int INC_LOW     = (FREQ_LOW * 65536) / SAMPLE_RATE;
    localparam int INC_HIGH    = (FREQ_HIGH * 65536) / SAMPLE_RATE;
    localparam int INC_B       = (FREQ_B * 65536) / SAMPLE_RATE;
    localparam int INC_THRUST  = (FREQ_THRUST * 65536) / SAMPLE_RATE;
    localparam int SUM_W       = 19;

    localparam logic signed [SUM_W-1:0] S_MAX = 32767;
    localparam logic signed [SUM_W-1:0] S_MIN = -32768;

    t_back_state             r_state, n_state;
    logic [ACC_W-1:0]        r_acc;
    logic [CNT_W-1:0]        r_cnt;
    logic [7:0]              r_explode;
    logic [7:0]              r_thump;
    logic [NUM_ENABLE-1:0]   r_enable;
    logic [15:0]             r_noise;
    logic [15:0]             r_phase [NUM_PH];
    logic [EXP_W-1:0]        r_exp_cnt;
    logic [SHOT_W-1:0]       r_shot_cnt;
    logic                    r_out_valid;
    logic [15:0]             r_out_sample;
    logic                    r_out_last;

    logic                    emit;
    logic                    last;
    logic [ACC_W-1:0]        acc_sum;
    logic [ACC_W-1:0]        acc_sub;

    logic [15:0]             noise_next;
    logic                    nb;
    logic [15:0]             inc_a;
    logic [15:0]             inc_thump;
    logic [15:0]             ph_next [NUM_PH];
    logic signed [9:0]       e_off;
    logic [6:0]              e_vol6;
    logic signed [17:0]      e_prod;
    logic signed [SUM_W-1:0] t_noise, t_exp, t_thump, t_a, t_b, t_shot, t_thr;
    logic signed [SUM_W-1:0] s_sum;
    logic [15:0]             s_clamp;

    // rate accumulator
    assign acc_sum = r_acc + ACC_W'(i_cmd.data[3:0]) * ACC_W'(SAMPLE_RATE);
    assign acc_sub = r_acc - ACC_W'(CPU_CLOCK);
    assign last    = (acc_sub < ACC_W'(CPU_CLOCK)) || (r_cnt == CNT_W'(MAX_SAMPLES - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && i_cmd.kind == CMD_CYCLES
                        && acc_sum >= ACC_W'(CPU_CLOCK)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (emit && last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_cmd_pop = 1'b0;
        emit      = 1'b0;
        case (r_state)
            ST_IDLE: o_cmd_pop = i_cmd_valid;
            ST_RUN:  emit      = !r_out_valid || i_out_pop;
            default: ;
        endcase
    end

    // mixer
    assign noise_next = {r_noise[0] ^ r_noise[1] ^ r_noise[4] ^ r_noise[15], r_noise[15:1]};
    assign nb         = noise_next[0];
    assign inc_a      = r_enable[EN_A_HIGH] ? 16'(INC_HIGH) : 16'(INC_LOW);
    assign inc_thump  = 16'(40) + 16'({1'b0, r_thump[3:0]} + 5'd1) * 16'(12);

    assign ph_next[PH_A]      = r_phase[PH_A] + inc_a;
    assign ph_next[PH_B]      = r_phase[PH_B] + 16'(INC_B);
    assign ph_next[PH_THRUST] = r_phase[PH_THRUST] + 16'(INC_THRUST);
    assign ph_next[PH_THUMP]  = r_phase[PH_THUMP] + inc_thump;

    assign e_off  = $signed({2'b00, noise_next[7:0]}) - 10'sd128;
    assign e_vol6 = 7'({3'b000, r_explode[5:2]} + 7'd4) * 7'd6;
    assign e_prod = e_off * $signed({1'b0, e_vol6});

    always_comb begin
        t_noise = '0;
        t_exp   = '0;
        t_thump = '0;
        t_a     = '0;
        t_b     = '0;
        t_shot  = '0;
        t_thr   = '0;
        if (r_enable[EN_NOISE]) begin
            t_noise = nb ? SUM_W'(AMP_NOISE) : -SUM_W'(AMP_NOISE);
        end
        if (r_exp_cnt != '0) begin
            t_exp = SUM_W'(e_prod);
        end
        if (r_thump[4]) begin
            t_thump = ph_next[PH_THUMP][15] ? SUM_W'(AMP_THUMP) : -SUM_W'(AMP_THUMP);
        end
        if (r_enable[EN_TONE_A]) begin
            t_a = ph_next[PH_A][15] ? SUM_W'(AMP_A) : -SUM_W'(AMP_A);
        end
        if (r_enable[EN_TONE_B]) begin
            t_b = ph_next[PH_B][15] ? SUM_W'(AMP_B) : -SUM_W'(AMP_B);
        end
        if (r_shot_cnt != '0) begin
            t_shot = nb ? SUM_W'(AMP_SHOT) : -SUM_W'(AMP_SHOT);
        end
        if (r_enable[EN_THRUST]) begin
            t_thr = ph_next[PH_THRUST][15] ? SUM_W'(AMP_THRUST) : -SUM_W'(AMP_THRUST);
        end
        s_sum = t_noise + t_exp + t_thump + t_a + t_b + t_shot + t_thr;
        if (s_sum > S_MAX) begin
            s_clamp = 16'h7fff;
        end else if (s_sum < S_MIN) begin
            s_clamp = 16'h8000;
        end else begin
            s_clamp = s_sum[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_acc       <= '0;
            r_cnt       <= '0;
            r_explode   <= '0;
            r_thump     <= '0;
            r_enable    <= '0;
            r_noise     <= 16'd1;
            r_exp_cnt   <= '0;
            r_shot_cnt  <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_PH; i++) begin
                r_phase[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (o_cmd_pop) begin
                case (i_cmd.kind)
                    CMD_EXPLODE: begin
                        r_explode <= i_cmd.data;
                        r_exp_cnt <= EXP_W'(EXPLODE_LEN);
                    end
                    CMD_THUMP: r_thump <= i_cmd.data;
                    CMD_ENABLE: begin
                        r_enable[i_cmd.idx] <= i_cmd.data[7] | i_cmd.data[0];
                        if (i_cmd.idx == 3'(EN_SHOT) && (i_cmd.data[7] | i_cmd.data[0])) begin
                            r_shot_cnt <= SHOT_W'(SHOT_LEN);
                        end
                    end
                    CMD_CYCLES: begin
                        r_acc <= acc_sum;
                        r_cnt <= '0;
                    end
                    default: ;
                endcase
            end
            if (emit) begin
                r_acc   <= acc_sub;
                r_cnt   <= r_cnt + 1'b1;
                r_noise <= noise_next;
                if (r_exp_cnt != '0) begin
                    r_exp_cnt <= r_exp_cnt - 1'b1;
                end
                if (r_shot_cnt != '0) begin
                    r_shot_cnt <= r_shot_cnt - 1'b1;
                end
                if (r_thump[4]) begin
                    r_phase[PH_THUMP] <= ph_next[PH_THUMP];
                end
                if (r_enable[EN_TONE_A]) begin
                    r_phase[PH_A] <= ph_next[PH_A];
                end
                if (r_enable[EN_TONE_B]) begin
                    r_phase[PH_B] <= ph_next[PH_B];
                end
                if (r_enable[EN_THRUST]) begin
                    r_phase[PH_THRUST] <= ph_next[PH_THRUST];
                end
                r_out_valid <= 1'b1;
            end else if (i_out_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_sample <= s_clamp;
            r_out_last   <= last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_sample      = r_out_sample;
    assign o_last_sample = r_out_last;

endmodule

[hdl/noise_tone_sound_mixer_core.sv]
// Top level of the noise and tone sound mixer: front end, command queue, back end.
// Depends on ntsm_pkg, ntsm_front, ntsm_cmdq and ntsm_back.
//
//   channel   handshake            payload
//   input     push / full          i_req_type, i_address, i_write_value, i_cycles
//   result    empty / pop          o_sample, o_last_sample
//
// A bus write is taken by the back end while it is idle; a cycle report is added to the
// accumulator; the back-end sequencer then emits up to 15 samples, stalling while one waits.
// Ignored writes and zero-cycle reports are dropped at the front and never reach the queue.
// Reset is synchronous; the queue and result register come up empty.
// A stalled result holds its register; the back end stops, the queue fills, then full rises.
module noise_tone_sound_mixer_core #(
    parameter int SAMPLE_RATE = ntsm_pkg::SAMPLE_RATE_DEF,
    parameter int CPU_CLOCK   = ntsm_pkg::CPU_CLOCK_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_req_type,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_value,
    input  logic [3:0]  i_cycles,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_sample,
    output logic        o_last_sample
);
    import ntsm_pkg::*;

    logic q_full;
    logic q_wr;
    t_cmd q_wr_cmd;
    logic q_valid;
    t_cmd q_rd_cmd;
    logic q_rd;
    logic out_valid;

    ntsm_front u_front (
        .i_push        (push),
        .o_full        (full),
        .i_req_type    (i_req_type),
        .i_address     (i_address),
        .i_write_value (i_write_value),
        .i_cycles      (i_cycles),
        .i_q_full      (q_full),
        .o_q_wr        (q_wr),
        .o_q_cmd       (q_wr_cmd)
    );

    ntsm_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_cmd   (q_wr_cmd),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_valid (q_valid),
        .o_cmd   (q_rd_cmd)
    );

    ntsm_back #(
        .SAMPLE_RATE (SAMPLE_RATE),
        .CPU_CLOCK   (CPU_CLOCK)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (q_valid),
        .i_cmd         (q_rd_cmd),
        .o_cmd_pop     (q_rd),
        .i_out_pop     (pop && out_valid),
        .o_out_valid   (out_valid),
        .o_sample      (o_sample),
        .o_last_sample (o_last_sample)
    );

    assign empty = !out_valid;

endmodule

[hdl/ntsm_checker.sv]
// Port-level checker for the noise and tone sound mixer, bound to the top level.
// Depends only on the top-level ports.
module ntsm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [15:0] o_sample,
    input logic        o_last_sample
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_reset_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input full after reset");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_sample) && $stable(o_last_sample)))
        else $error("waiting result changed without pop");

endmodule

bind noise_tone_sound_mixer_core ntsm_checker u_ntsm_checker (.*);

[bench/ntsm_checker.sv]
// Checker of the noise and tone sound mixer: predicts the samples from the accepted items
// and compares them with the results that leave the block. Depends on ntsm_pkg.
`timescale 1ns / 100ps

module ntsm_scoreboard #(
    parameter int SAMPLE_RATE = ntsm_pkg::SAMPLE_RATE_DEF,
    parameter int CPU_CLOCK   = ntsm_pkg::CPU_CLOCK_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic        i_req_type,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_value,
    input  logic [3:0]  i_cycles,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [15:0] i_sample,
    input  logic        i_last_sample,
    output int          o_failures,
    output int          o_outstanding
);
    import ntsm_pkg::*;

    localparam int BOOM_LEN    = SAMPLE_RATE / 3;
    localparam int SHOT_LEN    = SAMPLE_RATE / 18;
    localparam int STEP_LOW    = int'((longint'(FREQ_LOW) * 65536) / SAMPLE_RATE);
    localparam int STEP_HIGH   = int'((longint'(FREQ_HIGH) * 65536) / SAMPLE_RATE);
    localparam int STEP_B      = int'((longint'(FREQ_B) * 65536) / SAMPLE_RATE);
    localparam int STEP_THRUST = int'((longint'(FREQ_THRUST) * 65536) / SAMPLE_RATE);
    localparam int BOOM_GAIN   = 6;
    localparam int THUMP_BASE  = 40;
    localparam int THUMP_SCALE = 12;

    typedef struct packed {
        logic [15:0] level;
        logic        last;
    } t_due_sample;

    t_due_sample due_samples[$];

    logic [7:0]            boom_level;
    logic [7:0]            thump_ctrl;
    logic [NUM_ENABLE-1:0] enables;
    logic [15:0]           lfsr;
    logic [15:0]           phase [NUM_PH];
    int                    boom_left;
    int                    shot_left;
    logic [31:0]           rate_acc;

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        o_failures++;
    endtask

    function automatic int tone_step(input int idx, input int inc, input int amp);
        phase[idx] = phase[idx] + inc[15:0];
        return phase[idx][15] ? amp : -amp;
    endfunction

    function automatic logic [15:0] mix_next_sample();
        int   mix;
        int   vol;
        logic fb;
        logic nb;
        fb   = lfsr[0] ^ lfsr[1] ^ lfsr[4] ^ lfsr[15];
        lfsr = {fb, lfsr[15:1]};
        nb   = lfsr[0];
        mix  = 0;
        if (enables[EN_NOISE])
            mix += nb ? AMP_NOISE : -AMP_NOISE;
        if (boom_left > 0) begin
            vol = int'(boom_level[5:2]) + 4;
            mix += (int'(lfsr[7:0]) - 128) * vol * BOOM_GAIN;
            boom_left--;
        end
        if (thump_ctrl[4])
            mix += tone_step(PH_THUMP, THUMP_BASE + (int'(thump_ctrl[3:0]) + 1) * THUMP_SCALE,
                             AMP_THUMP);
        if (enables[EN_TONE_A])
            mix += tone_step(PH_A, enables[EN_A_HIGH] ? STEP_HIGH : STEP_LOW, AMP_A);
        if (enables[EN_TONE_B])
            mix += tone_step(PH_B, STEP_B, AMP_B);
        if (shot_left > 0) begin
            mix += nb ? AMP_SHOT : -AMP_SHOT;
            shot_left--;
        end
        if (enables[EN_THRUST])
            mix += tone_step(PH_THRUST, STEP_THRUST, AMP_THRUST);
        if (mix > 32767)
            mix = 32767;
        if (mix < -32768)
            mix = -32768;
        return mix[15:0];
    endfunction

    function automatic void apply_bus_write(input logic [15:0] addr, input logic [7:0] val);
        logic [14:0] a;
        int          idx;
        a = addr[14:0];
        if (a == ADDR_EXPLODE) begin
            boom_level = val;
            boom_left  = BOOM_LEN;
        end else if (a == ADDR_THUMP) begin
            thump_ctrl = val;
        end else if (a >= ADDR_ENABLE && a <= ADDR_ENABLE_END) begin
            idx = int'(a[2:0]);
            enables[idx] = val[7] | val[0];
            if (idx == EN_SHOT && enables[EN_SHOT])
                shot_left = SHOT_LEN;
        end
    endfunction

    function automatic void advance_rate(input logic [3:0] cyc);
        t_due_sample batch[$];
        t_due_sample one;
        int          made;
        made = 0;
        rate_acc = rate_acc + 32'(int'(cyc) * SAMPLE_RATE);
        while (rate_acc >= 32'(CPU_CLOCK) && made < MAX_SAMPLES) begin
            rate_acc   = rate_acc - 32'(CPU_CLOCK);
            one.level  = mix_next_sample();
            one.last   = 1'b0;
            batch      = {batch, one};
            made++;
        end
        if (made > 0)
            batch[made - 1].last = 1'b1;
        foreach (batch[k])
            due_samples = {due_samples, batch[k]};
    endfunction

    always @(posedge i_clk) begin
        t_due_sample want;
        if (!i_rst_n) begin
            boom_level = '0;
            thump_ctrl = '0;
            enables    = '0;
            lfsr       = 16'd1;
            foreach (phase[k])
                phase[k] = '0;
            boom_left  = 0;
            shot_left  = 0;
            rate_acc   = '0;
            due_samples.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (due_samples.size() == 0) begin
                    report_mismatch($sformatf("sample %0d arrived with nothing pending",
                                              $signed(i_sample)));
                end else begin
                    want = due_samples.pop_front();
                    if (i_sample !== want.level)
                        report_mismatch($sformatf("sample got %0d, wanted %0d",
                                                  $signed(i_sample), $signed(want.level)));
                    if (i_last_sample !== want.last)
                        report_mismatch($sformatf("last flag got %b, wanted %b",
                                                  i_last_sample, want.last));
                end
            end
            if (i_push && !i_full) begin
                if (i_req_type)
                    advance_rate(i_cycles);
                else
                    apply_bus_write(i_address, i_write_value);
            end
        end
        o_outstanding = due_samples.size();
    end

endmodule

[bench/tb_top.sv]
// Top of the noise and tone sound mixer bench: clock, reset, item stimulus and verdict.
// Depends on ntsm_pkg, noise_tone_sound_mixer_core and ntsm_scoreboard.
`timescale 1ns / 100ps

module tb_top;
    import ntsm_pkg::*;

    localparam int IDLE_LIMIT  = 5000;
    localparam int MIN_ITEMS   = 150;
    localparam int TAIL_CYCLES = 40;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic        i_req_type;
    logic [15:0] i_address;
    logic [7:0]  i_write_value;
    logic [3:0]  i_cycles;
    logic        empty;
    logic        pop = 1'b0;
    logic [15:0] o_sample;
    logic        o_last_sample;

    int failures;
    int outstanding;
    int send_idle_pct;
    int take_idle_pct;
    int sent;
    int idle_cycles;

    noise_tone_sound_mixer_core dut (.*);

    ntsm_scoreboard u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_req_type   (i_req_type),
        .i_address    (i_address),
        .i_write_value(i_write_value),
        .i_cycles     (i_cycles),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_sample     (o_sample),
        .i_last_sample(o_last_sample),
        .o_failures   (failures),
        .o_outstanding(outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        pop <= ($urandom_range(99) >= take_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_item(input logic rt, input logic [15:0] addr, input logic [7:0] val,
                             input logic [3:0] cyc);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push          <= 1'b1;
        i_req_type    <= rt;
        i_address     <= addr;
        i_write_value <= val;
        i_cycles      <= cyc;
        do @(posedge i_clk); while (full);
        sent++;
    endtask

    task automatic write_reg(input logic [15:0] addr, input logic [7:0] val);
        push_item(1'b0, addr, val, 4'($urandom));
    endtask

    task automatic report_cycles(input logic [3:0] cyc);
        push_item(1'b1, 16'($urandom), 8'($urandom), cyc);
    endtask

    task automatic drain_samples();
        @(negedge i_clk);
        push <= 1'b0;
        while (outstanding != 0)
            @(negedge i_clk);
    endtask

    initial begin
        int          stage;
        int          pick;
        logic [15:0] addr;
        logic [3:0]  cyc;
        push          = 1'b0;
        i_req_type    = 1'b0;
        i_address     = '0;
        i_write_value = '0;
        i_cycles      = '0;
        i_rst_n       = 1'b0;
        send_idle_pct = 25;
        take_idle_pct = 84;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        report_cycles(4'd0);
        write_reg(16'h0000, 8'hff);
        write_reg(16'h7fff, 8'hff);
        report_cycles(4'd15);
        report_cycles(4'd15);
        report_cycles(4'd15);
        write_reg({1'b0, ADDR_ENABLE} + 16'(EN_NOISE), 8'h01);
        write_reg({1'b0, ADDR_ENABLE} + 16'(EN_TONE_A), 8'h80);
        write_reg({1'b1, ADDR_ENABLE} + 16'(EN_A_HIGH), 8'h81);
        write_reg({1'b0, ADDR_ENABLE} + 16'(EN_TONE_B), 8'h01);
        write_reg({1'b0, ADDR_ENABLE} + 16'(EN_THRUST), 8'h80);
        write_reg({1'b0, ADDR_ENABLE} + 16'(EN_SHOT), 8'h01);
        write_reg({1'b0, ADDR_THUMP}, 8'h1f);
        write_reg({1'b1, ADDR_EXPLODE}, 8'hff);
        repeat (7) report_cycles(4'd15);
        write_reg({1'b0, ADDR_ENABLE} + 16'd6, 8'hff);
        write_reg({1'b0, ADDR_ENABLE} + 16'd7, 8'hff);
        write_reg({1'b0, ADDR_ENABLE} + 16'(EN_SHOT), 8'h7e);
        write_reg({1'b0, ADDR_ENABLE} + 16'(EN_TONE_A), 8'h00);
        write_reg({1'b0, ADDR_EXPLODE}, 8'h00);
        write_reg({1'b1, ADDR_THUMP}, 8'h00);
        report_cycles(4'd1);
        drain_samples();

        stage = 0;
        while (sent < MIN_ITEMS) begin
            if (stage == 0 && sent >= MIN_ITEMS / 3) begin
                drain_samples();
                send_idle_pct = 84;
                take_idle_pct = 25;
                stage = 1;
            end else if (stage == 1 && sent >= 2 * MIN_ITEMS / 3) begin
                drain_samples();
                send_idle_pct = 0;
                take_idle_pct = 0;
                stage = 2;
            end
            pick = $urandom_range(99);
            if (pick < 65) begin
                cyc = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                               : 4'($urandom_range(15, 8));
                report_cycles(cyc);
            end else if (pick < 90) begin
                case ($urandom_range(2))
                    0: addr = {1'b0, ADDR_EXPLODE};
                    1: addr = {1'b0, ADDR_THUMP};
                    default: addr = {1'b0, ADDR_ENABLE} + 16'($urandom_range(NUM_ENABLE - 1));
                endcase
                addr[15] = 1'($urandom);
                write_reg(addr, 8'($urandom));
            end else begin
                push_item(1'($urandom), 16'($urandom), 8'($urandom), 4'($urandom));
            end
        end
        drain_samples();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (failures == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
